>>> hdl/mtc_pkg.sv
// Shared types, case tables and corner helpers for the marching tetrahedra cell unit.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package mtc_pkg;

   localparam int NumTets    = 6;
   localparam int NumCorners = 8;
   localparam int NumAxes    = 3;
   localparam int NumVerts   = 3;
   localparam int FracBits   = 16;
   localparam logic [16:0] MuOne = 17'h10000;

   typedef logic signed [31:0] sample_type;
   typedef logic signed [32:0] coord_type;
   typedef coord_type  coord3_type  [NumAxes];
   typedef sample_type sample8_type [NumCorners];
   typedef logic [31:0] vert_type [NumAxes];

   typedef struct packed {
      logic signed [31:0] cell_x;
      logic signed [31:0] cell_y;
      logic signed [31:0] cell_z;
      logic [30:0]        cell_size;
      logic signed [31:0] val0;
      logic signed [31:0] val1;
      logic signed [31:0] val2;
      logic signed [31:0] val3;
      logic signed [31:0] val4;
      logic signed [31:0] val5;
      logic signed [31:0] val6;
      logic signed [31:0] val7;
   } req_type;

   typedef struct packed {
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
      logic signed [31:0] bx;
      logic signed [31:0] by;
      logic signed [31:0] bz;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
      logic               last;
      logic               empty_res;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } lane_status_type;

   // corner number of local vertex k of tetrahedron t
   function automatic logic [2:0] tet_corner(input logic [2:0] t, input logic [1:0] k);
      logic [11:0] row;
      case (t)
         3'd0:    row = {3'd0, 3'd1, 3'd5, 3'd2};
         3'd1:    row = {3'd0, 3'd4, 3'd2, 3'd5};
         3'd2:    row = {3'd2, 3'd1, 3'd5, 3'd3};
         3'd3:    row = {3'd2, 3'd4, 3'd6, 3'd5};
         3'd4:    row = {3'd2, 3'd7, 3'd3, 3'd5};
         3'd5:    row = {3'd2, 3'd6, 3'd7, 3'd5};
         default: row = '0;
      endcase
      return row[(3 - k) * 3 +: 3];
   endfunction

   // number of triangles for a below-iso mask
   function automatic logic [1:0] tri_count(input logic [3:0] mask);
      case (mask)
         4'h0, 4'hF:                         return 2'd0;
         4'h3, 4'h5, 4'h6, 4'h9, 4'hA, 4'hC: return 2'd2;
         default:                            return 2'd1;
      endcase
   endfunction

   // edge code {from, to} in local vertices for triangle slot 0..5
   function automatic logic [3:0] edge_code(input logic [3:0] mask, input logic [2:0] slot);
      logic [23:0] row;
      case (mask)
         4'h1:    row = 24'h123000;
         4'h2:    row = 24'h476000;
         4'h3:    row = 24'h237762;
         4'h4:    row = 24'h89B000;
         4'h5:    row = 24'h1B316B;
         4'h6:    row = 24'h17B21B;
         4'h7:    row = 24'hECD000;
         4'h8:    row = 24'hCED000;
         4'h9:    row = 24'h71B12B;
         4'hA:    row = 24'hB1361B;
         4'hB:    row = 24'h98B000;
         4'hC:    row = 24'h327672;
         4'hD:    row = 24'h746000;
         4'hE:    row = 24'h213000;
         default: row = '0;
      endcase
      return row[(5 - slot) * 4 +: 4];
   endfunction

   // exact corner coordinate on one axis
   function automatic coord_type corner_coord(input logic signed [31:0] base,
                                              input logic [30:0] size, input logic sel);
      return {base[31], base} + (sel ? {2'b00, size} : 33'd0);
   endfunction

endpackage

>>> hdl/mtc_tet_lane.sv
// Classification lane: below-iso mask and triangle count of one tetrahedron.
// Depends on mtc_pkg.
`timescale 1ns / 1ps

module mtc_tet_lane import mtc_pkg::*; (
   input  logic [2:0]  tet_index,
   input  sample8_type vals,
   input  sample_type  iso_level,
   output logic [3:0]  mask,
   output logic [1:0]  count
);

   // test each local vertex against the threshold
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         mask[k] = vals[tet_corner(tet_index, 2'(k))] < iso_level;
      end
   end

   assign count = tri_count(mask);

endmodule

>>> hdl/mtc_interp.sv
// Vertex lane: edge interpolation with a bit-serial divider and one multiply per axis.
// Depends on mtc_pkg.
`timescale 1ns / 1ps

module mtc_interp import mtc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            ack,
   input  sample_type      iso_level,
   input  sample_type      val_a,
   input  sample_type      val_b,
   input  coord3_type      p1,
   input  coord3_type      p2,
   output lane_status_type status,
   output vert_type        vertex
);

   typedef enum logic [2:0] {L_IDLE, L_DIV, L_MUL, L_ADD, L_DONE} lane_state_type;

   lane_state_type     state_ff;
   logic [32:0]        dmag_ff;
   logic [33:0]        rem_ff;
   logic [15:0]        quo_ff;
   logic [3:0]         cnt_ff;
   logic               neg_mu_ff, zero_den_ff, sat_ff;
   logic [16:0]        mu_ff;
   coord_type          p1_ff   [NumAxes];
   logic [30:0]        span_ff [NumAxes];
   logic               dneg_ff [NumAxes];
   logic [47:0]        prod_ff [NumAxes];
   logic [31:0]        res_ff  [NumAxes];

   logic signed [32:0] num, den;
   logic [32:0]        nmag, dmag;
   logic signed [33:0] span [NumAxes];
   logic [33:0]        span_mag [NumAxes];
   logic [33:0]        rem2, rem_in;
   logic               take_bit;
   logic [15:0]        quo_in;
   logic [16:0]        mu_in;
   logic [31:0]        off  [NumAxes];
   logic [33:0]        sum  [NumAxes];

   // operand magnitudes and signs
   always_comb begin
      num  = {iso_level[31], iso_level} - {val_a[31], val_a};
      den  = {val_b[31], val_b} - {val_a[31], val_a};
      nmag = num[32] ? 33'(-num) : 33'(num);
      dmag = den[32] ? 33'(-den) : 33'(den);
      for (int k = 0; k < NumAxes; k++) begin
         span[k]     = {p2[k][32], p2[k]} - {p1[k][32], p1[k]};
         span_mag[k] = span[k][33] ? 34'(-span[k]) : 34'(span[k]);
      end
   end

   // one quotient bit per cycle
   always_comb begin
      rem2     = {rem_ff[32:0], 1'b0};
      take_bit = rem2 >= {1'b0, dmag_ff};
      rem_in   = take_bit ? rem2 - {1'b0, dmag_ff} : rem2;
      quo_in   = {quo_ff[14:0], take_bit};
      mu_in    = zero_den_ff ? 17'd0 : (sat_ff ? MuOne : {1'b0, quo_in});
   end

   // signed offset added to the start corner
   always_comb begin
      for (int k = 0; k < NumAxes; k++) begin
         off[k] = prod_ff[k][47:FracBits];
         sum[k] = {p1_ff[k][32], p1_ff[k]} +
                  ((neg_mu_ff ^ dneg_ff[k]) ? 34'(-{2'b00, off[k]}) : {2'b00, off[k]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
      end else begin
         case (state_ff)
            L_IDLE: begin
               if (start) begin
                  state_ff <= L_DIV;
               end
            end
            L_DIV: begin
               if (cnt_ff == 4'd15) begin
                  state_ff <= L_MUL;
               end
            end
            L_MUL:   state_ff <= L_ADD;
            L_ADD:   state_ff <= L_DONE;
            L_DONE: begin
               if (ack) begin
                  state_ff <= L_IDLE;
               end
            end
            default: state_ff <= L_IDLE;
         endcase
      end

      // datapath: load, iterate, multiply, add
      case (state_ff)
         L_IDLE: begin
            dmag_ff     <= dmag;
            rem_ff      <= {1'b0, nmag};
            quo_ff      <= '0;
            cnt_ff      <= '0;
            neg_mu_ff   <= num[32] ^ den[32];
            zero_den_ff <= dmag == 33'd0;
            sat_ff      <= nmag >= dmag;
            for (int k = 0; k < NumAxes; k++) begin
               p1_ff[k]   <= p1[k];
               span_ff[k] <= span_mag[k][30:0];
               dneg_ff[k] <= span[k][33];
            end
         end
         L_DIV: begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + 4'd1;
            mu_ff  <= mu_in;
         end
         L_MUL: begin
            for (int k = 0; k < NumAxes; k++) begin
               prod_ff[k] <= mu_ff * {17'd0, span_ff[k]};
            end
         end
         L_ADD: begin
            for (int k = 0; k < NumAxes; k++) begin
               res_ff[k] <= sum[k][31:0];
            end
         end
         default: begin
         end
      endcase
   end

   assign status.busy = state_ff != L_IDLE;
   assign status.done = state_ff == L_DONE;
   assign vertex      = res_ff;

   a_div_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == L_DIV && cnt_ff == 4'd15) |=> state_ff == L_MUL)
      else $error("divider overran its step count");
   a_mu_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == L_ADD |-> mu_ff <= MuOne)
      else $error("interpolation ratio above one");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == L_IDLE)
      else $error("lane started while busy");

endmodule

>>> hdl/marching_tetrahedra_cell_unit.sv
// Top level: cell buffer, six classification lanes, triangle sequencer, three vertex lanes.
// Depends on mtc_pkg, mtc_tet_lane and mtc_interp.
//
//   channel  ports                      direction  beat
//   req      req_valid/ready/payload    in         one cell
//   rsp      rsp_valid/ready/payload    out        one triangle or one empty mark
//   csr      csr_write_enable/data      in         iso_level, no wait
//
// Each triangle passes through a scan state that also loads the vertex lanes, 16 divider
// steps (one quotient bit a cycle), one multiply, one add and one output load.
// A tetrahedron without triangles is only scanned and skipped; an empty cell goes through S_EMPTY.
// A one-cell buffer takes the next cell while the current one is worked on.
// Reset is synchronous and clears the state machines and the buffer and result valid flags; iso_level resets to 0.
// A stalled result holds in the output register and stalls the vertex lanes behind it.
`timescale 1ns / 1ps

module marching_tetrahedra_cell_unit import mtc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WAIT, S_EMPTY} state_type;

   state_type       state_ff;
   sample_type      iso_ff;
   req_type         hold_ff;
   logic            hold_valid_ff;
   logic signed [31:0] base_ff [NumAxes];
   logic [30:0]     size_ff;
   sample8_type     val_ff;
   logic [3:0]      mask_ff [NumTets];
   logic [3:0]      total_ff, emitted_ff;
   logic [2:0]      tet_ff;
   logic [1:0]      tri_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_ff;

   sample8_type     hold_val;
   logic [3:0]      lane_mask  [NumTets];
   logic [1:0]      lane_count [NumTets];
   logic [3:0]      total_in;
   logic            take, out_free, lanes_done, lane_start, lane_ack, rsp_load;
   logic [3:0]      cur_mask;
   logic [1:0]      cur_count;
   logic            is_last;
   lane_status_type vstat [NumVerts];
   vert_type        vres  [NumVerts];
   sample_type      va [NumVerts], vb [NumVerts];
   coord3_type      vp1 [NumVerts], vp2 [NumVerts];

   assign hold_val = '{hold_ff.val0, hold_ff.val1, hold_ff.val2, hold_ff.val3,
                       hold_ff.val4, hold_ff.val5, hold_ff.val6, hold_ff.val7};

   // classify the buffered cell, one lane per tetrahedron
   for (genvar t = 0; t < NumTets; t++) begin : g_tet
      mtc_tet_lane u_tet (
         .tet_index (3'(t)),
         .vals      (hold_val),
         .iso_level (iso_ff),
         .mask      (lane_mask[t]),
         .count     (lane_count[t])
      );
   end

   // merge lane counts into the cell total
   always_comb begin
      total_in = '0;
      for (int t = 0; t < NumTets; t++) begin
         total_in = total_in + {2'b00, lane_count[t]};
      end
   end

   assign req_ready  = !hold_valid_ff;
   assign take       = state_ff == S_IDLE && hold_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign cur_mask   = mask_ff[tet_ff];
   assign cur_count  = tri_count(cur_mask);
   assign lane_start = state_ff == S_SCAN && tri_ff < cur_count;
   assign lanes_done = vstat[0].done && vstat[1].done && vstat[2].done;
   assign lane_ack   = state_ff == S_WAIT && lanes_done && out_free;
   assign rsp_load   = lane_ack || (state_ff == S_EMPTY && out_free);
   assign is_last    = emitted_ff + 4'd1 == total_ff;

   // steer corners of the current triangle into the vertex lanes
   always_comb begin
      logic [3:0] e;
      logic [2:0] c1, c2;
      for (int v = 0; v < NumVerts; v++) begin
         e     = edge_code(cur_mask, tri_ff[0] ? 3'(3 + v) : 3'(v));
         c1    = tet_corner(tet_ff, e[3:2]);
         c2    = tet_corner(tet_ff, e[1:0]);
         va[v] = val_ff[c1];
         vb[v] = val_ff[c2];
         for (int k = 0; k < NumAxes; k++) begin
            vp1[v][k] = corner_coord(base_ff[k], size_ff, c1[2 - k]);
            vp2[v][k] = corner_coord(base_ff[k], size_ff, c2[2 - k]);
         end
      end
   end

   for (genvar v = 0; v < NumVerts; v++) begin : g_vert
      mtc_interp u_interp (
         .clock     (clock),
         .reset     (reset),
         .start     (lane_start),
         .ack       (lane_ack),
         .iso_level (iso_ff),
         .val_a     (va[v]),
         .val_b     (vb[v]),
         .p1        (vp1[v]),
         .p2        (vp2[v]),
         .status    (vstat[v]),
         .vertex    (vres[v])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         iso_ff        <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            iso_ff <= csr_write_data;
         end

         // buffer one cell beat
         if (req_valid && req_ready) begin
            hold_valid_ff <= 1'b1;
         end else if (take) begin
            hold_valid_ff <= 1'b0;
         end

         // load a new result beat, or drop the current one once taken
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (take) begin
                  state_ff <= (total_in == 4'd0) ? S_EMPTY : S_SCAN;
               end
            end
            S_SCAN: begin
               if (lane_start) begin
                  state_ff <= S_WAIT;
               end else begin
                  tet_ff <= tet_ff + 3'd1;
                  tri_ff <= '0;
               end
            end
            S_WAIT: begin
               if (lane_ack) begin
                  rsp_ff.ax        <= vres[0][0];
                  rsp_ff.ay        <= vres[0][1];
                  rsp_ff.az        <= vres[0][2];
                  rsp_ff.bx        <= vres[1][0];
                  rsp_ff.by        <= vres[1][1];
                  rsp_ff.bz        <= vres[1][2];
                  rsp_ff.cx        <= vres[2][0];
                  rsp_ff.cy        <= vres[2][1];
                  rsp_ff.cz        <= vres[2][2];
                  rsp_ff.last      <= is_last;
                  rsp_ff.empty_res <= 1'b0;
                  emitted_ff       <= emitted_ff + 4'd1;
                  tri_ff           <= tri_ff + 2'd1;
                  state_ff         <= is_last ? S_IDLE : S_SCAN;
               end
            end
            S_EMPTY: begin
               if (out_free) begin
                  rsp_ff   <= '{last: 1'b1, empty_res: 1'b1, default: '0};
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase

         // load the working cell
         if (take) begin
            base_ff[0] <= hold_ff.cell_x;
            base_ff[1] <= hold_ff.cell_y;
            base_ff[2] <= hold_ff.cell_z;
            size_ff    <= hold_ff.cell_size;
            val_ff     <= hold_val;
            mask_ff    <= lane_mask;
            total_ff   <= total_in;
            emitted_ff <= '0;
            tet_ff     <= '0;
            tri_ff     <= '0;
         end
      end

      if (req_valid && req_ready) begin
         hold_ff <= req_payload;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_lanes_together: assert property (@(posedge clock) disable iff (reset)
      vstat[0].done == vstat[1].done && vstat[1].done == vstat[2].done)
      else $error("vertex lanes out of step");
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_WAIT) |-> emitted_ff < total_ff)
      else $error("more triangles than the cell holds");
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> tet_ff < 3'(NumTets))
      else $error("scan ran past the last tetrahedron");
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.empty_res) |-> rsp_ff.last)
      else $error("empty mark without last");

endmodule
